// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL files of the humidity sensor frame decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define HSFD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("hsfd assertion failed");
`define HSFD_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("hsfd assertion failed");
`else
`define HSFD_ASSERT(lbl, clk, rstn, prop)
`define HSFD_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// File: rtl/core/hsfd_pkg.sv
// Types, constants and the CRC-8 step of the humidity sensor frame decoder.
package hsfd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam int unsigned TEMP_SPAN   = 17500;
  localparam int unsigned HUMID_SPAN  = 10000;
  localparam int unsigned TEMP_OFFSET = 4500;
  localparam int unsigned FULL_SCALE  = 65535;

  localparam int unsigned FIFO_DEPTH = 2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [13:0]        humid_centi;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] temp_word;
    logic [15:0] humid_word;
    logic [1:0]  status;
  } raw_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/core/hsfd_front.sv
// Front end: byte position tracking, word assembly and CRC check per frame.
module hsfd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  hsfd_pkg::in_item_t in_data,
  output logic               in_stall,
  input  logic               fifo_full,
  output logic               push,
  output hsfd_pkg::raw_t     push_data
);

  typedef enum logic [2:0] {
    POS_T_HI,
    POS_T_LO,
    POS_T_CRC,
    POS_H_HI,
    POS_H_LO,
    POS_H_CRC
  } pos_t;

  pos_t        pos_r, pos_nxt, pos_eff;
  logic [7:0]  crc_r, crc_nxt, crc_base;
  logic [15:0] temp_word_r, temp_word_nxt;
  logic [15:0] humid_word_r, humid_word_nxt;
  logic        temp_bad_r, temp_bad_nxt;
  logic        restart;
  logic        accept;
  logic        last_byte;

  assign in_stall = fifo_full;
  assign accept   = in_valid && !fifo_full;
  assign restart  = in_data.frame_start || (pos_r > POS_H_CRC);
  assign pos_eff  = restart ? POS_T_HI : pos_r;
  assign crc_base = restart ? hsfd_pkg::CRC_INIT : crc_r;

  always_comb begin
    pos_nxt        = pos_r;
    crc_nxt        = crc_r;
    temp_word_nxt  = temp_word_r;
    humid_word_nxt = humid_word_r;
    temp_bad_nxt   = temp_bad_r;
    last_byte      = 1'b0;
    if (accept) begin
      unique case (pos_eff)
        POS_T_HI: begin
          temp_word_nxt = {in_data.rx_byte, 8'h00};
          crc_nxt       = hsfd_pkg::crc8_update(hsfd_pkg::CRC_INIT, in_data.rx_byte);
          pos_nxt       = POS_T_LO;
        end
        POS_T_LO: begin
          temp_word_nxt = {temp_word_r[15:8], in_data.rx_byte};
          crc_nxt       = hsfd_pkg::crc8_update(crc_base, in_data.rx_byte);
          pos_nxt       = POS_T_CRC;
        end
        POS_T_CRC: begin
          temp_bad_nxt = (crc_base != in_data.rx_byte);
          crc_nxt      = hsfd_pkg::CRC_INIT;
          pos_nxt      = POS_H_HI;
        end
        POS_H_HI: begin
          humid_word_nxt = {in_data.rx_byte, 8'h00};
          crc_nxt        = hsfd_pkg::crc8_update(hsfd_pkg::CRC_INIT, in_data.rx_byte);
          pos_nxt        = POS_H_LO;
        end
        POS_H_LO: begin
          humid_word_nxt = {humid_word_r[15:8], in_data.rx_byte};
          crc_nxt        = hsfd_pkg::crc8_update(crc_base, in_data.rx_byte);
          pos_nxt        = POS_H_CRC;
        end
        POS_H_CRC: begin
          last_byte = 1'b1;
          crc_nxt   = hsfd_pkg::CRC_INIT;
          pos_nxt   = POS_T_HI;
        end
        default: begin
          crc_nxt = hsfd_pkg::CRC_INIT;
          pos_nxt = POS_T_HI;
        end
      endcase
    end
  end

  assign push                 = last_byte;
  assign push_data.temp_word  = temp_word_r;
  assign push_data.humid_word = humid_word_r;
  assign push_data.status     = {(crc_base != in_data.rx_byte), temp_bad_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= POS_T_HI;
      crc_r        <= hsfd_pkg::CRC_INIT;
      temp_word_r  <= '0;
      humid_word_r <= '0;
      temp_bad_r   <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      crc_r        <= crc_nxt;
      temp_word_r  <= temp_word_nxt;
      humid_word_r <= humid_word_nxt;
      temp_bad_r   <= temp_bad_nxt;
    end
  end

endmodule

// File: rtl/core/hsfd_fifo.sv
// Small register queue between the front end and the conversion back end.
`include "assert_macros.svh"

module hsfd_fifo #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `HSFD_ASSERT(a_no_push_full, clk, rst_n, !(push && full))
  `HSFD_ASSERT(a_no_pop_empty, clk, rst_n, !(pop && empty))
  `HSFD_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(DEPTH))
  `HSFD_ASSERT(a_push_fills, clk, rst_n, (do_push && !do_pop) |=> !empty)

endmodule

// File: rtl/core/hsfd_back.sv
// Back end: two-stage scaling of the raw words into hundredths, output register.
module hsfd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fifo_empty,
  input  hsfd_pkg::raw_t      fifo_data,
  output logic                pop,
  output logic                out_valid,
  output hsfd_pkg::out_item_t out_data,
  input  logic                out_stall
);

  logic                s1_valid_r, s1_valid_nxt;
  logic [30:0]         s1_tprod_r, s1_tprod_nxt;
  logic [30:0]         s1_hprod_r, s1_hprod_nxt;
  logic [1:0]          s1_status_r, s1_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  hsfd_pkg::out_item_t out_data_r, out_data_nxt;
  logic                s1_ready, s2_ready;
  logic [15:0]         tq, hq;

  function automatic logic [15:0] div_full_scale(input logic [30:0] x);
    logic [14:0] q0;
    logic [16:0] r;
    q0 = x[30:16];
    r  = {1'b0, x[15:0]} + {2'b00, q0};
    return {1'b0, q0} + ((r >= 17'(hsfd_pkg::FULL_SCALE)) ? 16'd1 : 16'd0);
  endfunction

  assign s2_ready = !out_valid_r || !out_stall;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign pop      = !fifo_empty && s1_ready;

  assign tq = div_full_scale(s1_tprod_r);
  assign hq = div_full_scale(s1_hprod_r);

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_tprod_nxt  = s1_tprod_r;
    s1_hprod_nxt  = s1_hprod_r;
    s1_status_nxt = s1_status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (s1_ready) begin
      s1_valid_nxt  = !fifo_empty;
      s1_tprod_nxt  = 31'(hsfd_pkg::TEMP_SPAN) * {15'd0, fifo_data.temp_word};
      s1_hprod_nxt  = 31'(hsfd_pkg::HUMID_SPAN) * {15'd0, fifo_data.humid_word};
      s1_status_nxt = fifo_data.status;
    end
    if (s2_ready) begin
      out_valid_nxt            = s1_valid_r;
      out_data_nxt.temp_centi  = 15'(tq - 16'(hsfd_pkg::TEMP_OFFSET));
      out_data_nxt.humid_centi = hq[13:0];
      out_data_nxt.status      = s1_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_tprod_r  <= s1_tprod_nxt;
    s1_hprod_r  <= s1_hprod_nxt;
    s1_status_r <= s1_status_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/humidity_sensor_frame_decoder.sv
// Top level of the humidity sensor frame decoder.
//
// Input channel (in_valid, in_data, in_stall): one sensor response byte per
// item with a frame_start mark; frame_start restarts the six-byte frame.
// Bytes in order: temperature high, low, CRC, humidity high, low, CRC.
// Output channel (out_valid, out_data, out_stall): one result per frame with
// temperature and humidity in hundredths and a two-bit CRC status.
// Throughput: one byte per cycle while in_stall is low, set by the CRC-8 step in
// the front end. After the sixth byte is accepted, the words go into the queue,
// are read into the multiply stage register, then reduced into the output register.
// A short queue sits between front end and back end; when out_stall holds the
// output, the back end and then the queue fill, and in_stall rises only when
// the queue is full. Results are never dropped.
// Reset (rst_n low, synchronous): position returns to the first byte, CRC to
// its initial value, queue and pipeline are emptied.
module humidity_sensor_frame_decoder #(
  parameter int unsigned FIFO_DEPTH = hsfd_pkg::FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  hsfd_pkg::in_item_t  in_data,
  output logic                in_stall,
  output logic                out_valid,
  output hsfd_pkg::out_item_t out_data,
  input  logic                out_stall
);

  localparam int unsigned RAW_W = $bits(hsfd_pkg::raw_t);

  logic             push, pop;
  logic             fifo_full, fifo_empty;
  hsfd_pkg::raw_t   push_data, pop_data;
  logic [RAW_W-1:0] pop_bits;

  hsfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .fifo_full (fifo_full),
    .push      (push),
    .push_data (push_data)
  );

  hsfd_fifo #(
    .WIDTH (RAW_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (RAW_W'(push_data)),
    .pop       (pop),
    .pop_data  (pop_bits),
    .full      (fifo_full),
    .empty     (fifo_empty)
  );

  assign pop_data = hsfd_pkg::raw_t'(pop_bits);

  hsfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .fifo_data  (pop_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall)
  );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the humidity sensor frame decoder: sensor bytes in, readings checked.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [7:0] SEED_CRC = 8'hFF;
  localparam logic [7:0] GEN_POLY = 8'h31;
  localparam int unsigned T_SPAN = 17500;
  localparam int unsigned H_SPAN = 10000;
  localparam int unsigned T_OFFSET = 4500;
  localparam int unsigned RAW_FULL = 65535;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned PHASE_ITEMS = 400;

  class reading_board;
    hsfd_pkg::out_item_t pending_readings[$];
    logic [2:0] position;
    logic [7:0] word_crc;
    logic [15:0] temp_raw;
    logic [15:0] humid_raw;
    logic temp_bad;
    int unsigned mismatches;

    function new();
      position = '0;
      word_crc = SEED_CRC;
      temp_raw = '0;
      humid_raw = '0;
      temp_bad = 1'b0;
      mismatches = 0;
    endfunction

    function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
      logic [7:0] acc;
      logic top;
      acc = crc ^ b;
      repeat (8) begin
        top = acc[7];
        acc = acc << 1;
        if (top) acc = acc ^ GEN_POLY;
      end
      return acc;
    endfunction

    function logic [7:0] word_check(logic [15:0] w);
      return crc_step(crc_step(SEED_CRC, w[15:8]), w[7:0]);
    endfunction

    function void note_byte(hsfd_pkg::in_item_t item);
      logic [2:0] slot;
      logic [7:0] b;
      logic humid_bad;
      int unsigned tq;
      int unsigned hq;
      int t;
      hsfd_pkg::out_item_t r;
      b = item.rx_byte;
      if (item.frame_start) begin
        position = '0;
        word_crc = SEED_CRC;
      end
      slot = position;
      if (slot > 3'd5) begin
        slot = '0;
        word_crc = SEED_CRC;
      end
      case (slot)
        3'd0: begin
          temp_raw = {b, 8'h00};
          word_crc = crc_step(SEED_CRC, b);
        end
        3'd1: begin
          temp_raw[7:0] = b;
          word_crc = crc_step(word_crc, b);
        end
        3'd2: begin
          temp_bad = (word_crc != b);
          word_crc = SEED_CRC;
        end
        3'd3: begin
          humid_raw = {b, 8'h00};
          word_crc = crc_step(SEED_CRC, b);
        end
        3'd4: begin
          humid_raw[7:0] = b;
          word_crc = crc_step(word_crc, b);
        end
        default: begin
          humid_bad = (word_crc != b);
          tq = (T_SPAN * temp_raw) / RAW_FULL;
          hq = (H_SPAN * humid_raw) / RAW_FULL;
          t = int'(tq) - int'(T_OFFSET);
          r.temp_centi = t[14:0];
          r.humid_centi = hq[13:0];
          r.status = {humid_bad, temp_bad};
          pending_readings.push_back(r);
          word_crc = SEED_CRC;
          position = '0;
          return;
        end
      endcase
      position = slot + 3'd1;
    endfunction

    function void check_reading(hsfd_pkg::out_item_t got);
      hsfd_pkg::out_item_t want;
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result temp_centi %0d humid_centi %0d status %0d",
                 $time, $signed(got.temp_centi), got.humid_centi, got.status);
        mismatches++;
        return;
      end
      want = pending_readings.pop_front();
      if (got.temp_centi !== want.temp_centi) begin
        $display("%0t: temp_centi expected %0d actual %0d", $time,
                 $signed(want.temp_centi), $signed(got.temp_centi));
        mismatches++;
      end
      if (got.humid_centi !== want.humid_centi) begin
        $display("%0t: humid_centi expected %0d actual %0d", $time,
                 want.humid_centi, got.humid_centi);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  hsfd_pkg::in_item_t in_data = '0;
  logic in_stall;
  logic out_valid;
  hsfd_pkg::out_item_t out_data;
  logic out_stall = 1'b0;

  int unsigned send_idle_pct = 31;
  int unsigned recv_stall_pct = 61;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  reading_board board = new();

  humidity_sensor_frame_decoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_data(in_data),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_data(out_data),
    .out_stall(out_stall)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_reading(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic mark);
    hsfd_pkg::in_item_t item;
    item.rx_byte = b;
    item.frame_start = mark;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_byte(item);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [15:0] t, input logic [15:0] h,
                            input logic t_ok, input logic h_ok, input logic mark);
    logic [7:0] tc;
    logic [7:0] hc;
    tc = board.word_check(t);
    hc = board.word_check(h);
    if (!t_ok) tc = tc ^ 8'($urandom_range(255, 1));
    if (!h_ok) hc = hc ^ 8'($urandom_range(255, 1));
    send_byte(t[15:8], mark);
    send_byte(t[7:0], 1'b0);
    send_byte(tc, 1'b0);
    send_byte(h[15:8], 1'b0);
    send_byte(h[7:0], 1'b0);
    send_byte(hc, 1'b0);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned phase_end;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_frame(16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_frame(16'h8000, 16'h7FFF, 1'b0, 1'b1, 1'b1);
    send_frame(16'h1234, 16'hFEDC, 1'b1, 1'b0, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 31;
          recv_stall_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_stall_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(99) < 85) begin
          send_frame(pick_word(), pick_word(), $urandom_range(3) != 0,
                     $urandom_range(3) != 0, $urandom_range(1));
        end else begin
          repeat ($urandom_range(5, 1)) send_byte(8'($urandom), $urandom_range(3) == 0);
        end
      end
    end
    in_valid <= 1'b0;

    while (board.pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/hsfd_pkg.sv
rtl/core/hsfd_front.sv
rtl/core/hsfd_fifo.sv
rtl/core/hsfd_back.sv
rtl/core/humidity_sensor_frame_decoder.sv
tb/tb_top.sv
